// ----- src/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_REAR  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_REAR   = 2'd3
  } dq_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  // Per-cycle command broadcast to every cell; at most one bit set.
  typedef struct packed {
    logic shift_in;   // push front: every cell takes its left neighbor
    logic put_rear;   // push rear: first empty cell takes the value
    logic shift_out;  // pop front: every cell takes its right neighbor
    logic drop_rear;  // pop rear: last occupied cell goes empty
  } dq_ctl_t;

endpackage

`default_nettype wire

// ----- src/double_ended_queue.sv -----
// Top level of the double-ended queue: control, cell row and result register.
//
//   channel   direction  ports                                    width
//   in_       input      in_func, in_value                        2, 32 (signed)
//   out_      output     out_status, out_popped_value,            2, 32 (signed), 5
//                        out_occupancy
//
// Cycles: one transfer per clock on each side while out_ready is high; a result appears in the cycle
//   after its item and the next item can be taken in that same cycle.
// The result is decoded from the cell row and held in the output register.
// Reset: synchronous, active low; clears all cell valid bits, the count and
//   the output valid. Cell data is not reset.
// Stalls: in_ready falls only while a result waits and out_ready is low.
`default_nettype none

module double_ended_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dq_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dq_pkg::STAT_W-1:0]        out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_popped_value,
  output logic [dq_pkg::CNT_W-1:0]         out_occupancy
);
  import dq_pkg::*;

  // Cell row: cell 0 holds the front element, occupied cells are contiguous.
  logic              cell_valid [DEPTH];
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]  valid_vec;
  logic [DEPTH-1:0]  tail_vec;

  dq_ctl_t           ctl;
  logic              accept;
  logic              full, empty;
  logic [CNT_W-1:0]  count_r, count_nxt;

  dq_status_t        status;
  logic [DATA_W-1:0] popped;
  logic [DATA_W-1:0] rear_data;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [DATA_W-1:0] out_popped_value_r;
  logic [CNT_W-1:0]  out_occupancy_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  // Decode the operation into a command for the row.
  always_comb begin
    ctl       = '0;
    status    = ST_DONE;
    popped    = '0;
    count_nxt = count_r;
    case (dq_func_t'(in_func))
      FN_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.shift_in = accept;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      FN_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.put_rear = accept;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.shift_out = accept;
          popped        = cell_data[0];
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      FN_POP_REAR: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.drop_rear = accept;
          popped        = rear_data;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // The rear element is the one cell flagged as tail; OR-select it.
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | (cell_data[i] & {DATA_W{tail_vec[i]}});
    end
  end

  // Cell 0 sees the input as its left neighbor; the last cell sees an empty
  // right neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic              lv, rv;
    logic [DATA_W-1:0] ld, rd;

    if (g == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = in_value;
    end else begin : g_mid_l
      assign lv = cell_valid[g-1];
      assign ld = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[g+1];
      assign rd = cell_data[g+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .push_value  (in_value),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[g]),
      .data        (cell_data[g]),
      .tail        (tail_vec[g])
    );

    assign valid_vec[g] = cell_valid[g];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r       <= status;
      out_popped_value_r <= popped;
      out_occupancy_r    <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_value_r;
  assign out_occupancy    = out_occupancy_r;

  // Count tracks the number of occupied cells.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_vec)))
    else $error("count out of step with cell row");

  // Occupied cells form one run starting at cell 0.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("gap in cell row");

  // At most one rear element.
  a_one_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tail_vec))
    else $error("several tail cells");

  // A full report always carries full occupancy, an empty report zero.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> out_occupancy_r == CNT_W'(DEPTH))
    else $error("full status with partial occupancy");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_EMPTY) |->
      (out_occupancy_r == '0) && (out_popped_value_r == '0))
    else $error("empty status with data");

endmodule

`default_nettype wire

// ----- src/dq_cell.sv -----
// One storage cell of the shift-register deque.
`default_nettype none

module dq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dq_pkg::dq_ctl_t           ctl,
  input  logic [dq_pkg::DATA_W-1:0] push_value,
  input  logic                      left_valid,
  input  logic [dq_pkg::DATA_W-1:0] left_data,
  input  logic                      right_valid,
  input  logic [dq_pkg::DATA_W-1:0] right_data,
  output logic                      valid,
  output logic [dq_pkg::DATA_W-1:0] data,
  output logic                      tail
);
  import dq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.shift_in) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (ctl.put_rear) begin
      // first empty cell: left neighbor occupied, this one not
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = push_value;
      end
    end else if (ctl.shift_out) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (ctl.drop_rear) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign tail  = valid_r && !right_valid;

endmodule

`default_nettype wire

// ----- sim/dq_result_checker.sv -----
// Result checker for the double-ended queue: predicts each result and compares.
`timescale 1ns / 1ps

module dq_result_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [dq_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [dq_pkg::STAT_W-1:0]        out_status,
  input  logic signed [dq_pkg::DATA_W-1:0] out_popped_value,
  input  logic [dq_pkg::CNT_W-1:0]         out_occupancy,
  output int                               mismatch_count,
  output int                               outstanding
);
  import dq_pkg::*;

  typedef struct {
    dq_status_t               status;
    logic signed [DATA_W-1:0] popped;
    logic [CNT_W-1:0]         occupancy;
  } deque_result_t;

  // Shadow ring: contents, position of the front element, element count.
  logic signed [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned              head_pos;
  int unsigned              held;

  deque_result_t pending_results [$];

  function automatic deque_result_t predict_deque_op(dq_func_t op,
                                                     logic signed [DATA_W-1:0] v);
    deque_result_t r;
    int unsigned   slot;
    r.status = ST_DONE;
    r.popped = '0;
    case (op)
      FN_PUSH_FRONT: begin
        if (held >= DEPTH) r.status = ST_FULL;
        else begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          ring_mem[head_pos] = v;
          held++;
        end
      end
      FN_PUSH_REAR: begin
        if (held >= DEPTH) r.status = ST_FULL;
        else begin
          slot = (head_pos + held) % DEPTH;
          ring_mem[slot] = v;
          held++;
        end
      end
      FN_POP_FRONT: begin
        if (held == 0) r.status = ST_EMPTY;
        else begin
          r.popped = ring_mem[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          held--;
        end
      end
      default: begin
        if (held == 0) r.status = ST_EMPTY;
        else begin
          slot = (head_pos + held - 1) % DEPTH;
          r.popped = ring_mem[slot];
          held--;
        end
      end
    endcase
    r.occupancy = CNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    deque_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      pending_results.delete();
      head_pos = 0;
      held = 0;
      mismatch_count <= 0;
      outstanding <= 0;
    end else begin
      // A result never arrives before its item is accepted, so retire first.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: status %0d popped %0d occ %0d",
                 out_status, out_popped_value, out_occupancy);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_popped_value !== want.popped) begin
            $error("popped_value: expected %0d, got %0d", want.popped, out_popped_value);
            errs++;
          end
          if (out_occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_deque_op(dq_func_t'(in_func), in_value));
      mismatch_count <= mismatch_count + errs;
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- sim/tb_double_ended_queue.sv -----
// Testbench top for the double-ended queue: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int PHASE_ITEMS = 80;   // five pacing phases, about 400 random items
  localparam int CHUNK_ITEMS = 20;   // push/pop mix is redrawn every chunk
  localparam int HOLD_CYCLES = 64;   // long receiver hold-off in the pressure phase

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FUNC_W-1:0]        in_func  = FN_PUSH_FRONT;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_popped_value;
  logic [CNT_W-1:0]         out_occupancy;

  int mismatch_count;
  int outstanding;

  // Pacing knobs, percent of cycles; changed by the stimulus between phases.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 1'b0;

  double_ended_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_occupancy    (out_occupancy)
  );

  dq_result_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_occupancy    (out_occupancy),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a transfer never completes.
  initial begin
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver side. out_ready changes only at the falling edge. A hold request
  // keeps it low for a long stretch so results back up and in_ready drops
  // while the sender keeps offering.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One input transfer. Called at a falling edge, returns at a falling edge.
  // Random idle cycles come first; valid then stays up with a stable payload
  // until the rising edge that sees ready.
  task automatic offer_op(input dq_func_t op, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= op;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly full-range random data, with the extremes mixed in now and then.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // push_pct biases toward filling (high) or draining (low) the queue so that
  // both the full and the empty boundary get hit repeatedly.
  function automatic dq_func_t pick_op(int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
    return $urandom_range(1) ? FN_POP_REAR : FN_POP_FRONT;
  endfunction

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input bit long_hold);
    int push_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) hold_request = 1'b1;
    push_pct = 50;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        // Under pressure keep pushing so the block really backs up.
        if (long_hold && i == 0) push_pct = 85;
      end
      offer_op(pick_op(push_pct), pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: pops on an empty queue.
    offer_op(FN_POP_FRONT, 32'sd123);
    offer_op(FN_POP_REAR,  -32'sd5);
    // Push front from reset wraps the front position below zero.
    offer_op(FN_PUSH_FRONT, VAL_MIN);
    offer_op(FN_PUSH_REAR,  VAL_MAX);
    offer_op(FN_PUSH_FRONT, -1);
    offer_op(FN_PUSH_REAR,  '0);
    // Drain from both ends back to empty.
    offer_op(FN_POP_REAR,  '0);
    offer_op(FN_POP_FRONT, '0);
    offer_op(FN_POP_FRONT, '0);
    offer_op(FN_POP_REAR,  '0);
    // Fill to capacity from both ends, then push on a full queue.
    for (int i = 0; i < DEPTH; i++)
      offer_op((i % 2) ? FN_PUSH_REAR : FN_PUSH_FRONT,
               (i % 2) ? (32'sh5A5A_0000 + i) : (32'shA5A5_0000 + i));
    offer_op(FN_PUSH_FRONT, 32'sh1111_1111);
    offer_op(FN_PUSH_REAR,  32'sh2222_2222);

    // Random part, one phase per pacing style.
    run_random_phase(0,  0,  1'b0);  // back to back
    run_random_phase(56, 0,  1'b0);  // sender gaps
    run_random_phase(0,  56, 1'b0);  // receiver stalls
    run_random_phase(25, 25, 1'b0);  // both
    run_random_phase(0,  0,  1'b1);  // long receiver hold-off

    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Drain every expected result, then give stray results time to show.
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
